>>> sv/ir_edge_duration_capture_core_macros.svh
// assertion helpers shared by the capture core
`ifndef IR_EDGE_DURATION_CAPTURE_CORE_MACROS_SVH
`define IR_EDGE_DURATION_CAPTURE_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define IREDC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("iredc: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define IREDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("iredc: next-cycle check failed");

`endif

>>> sv/iredc_pkg.sv
package iredc_pkg;

   localparam int RING_DEPTH = 1024;
   localparam int UNIT_US    = 21;
   localparam int PTR_W      = $clog2(RING_DEPTH);

   localparam logic [15:0] MAX_UNITS     = 16'hFFFE;
   localparam logic [15:0] END_MARK      = 16'hFFFF;
   localparam logic [31:0] TIMEOUT_RESET = 32'd10000;

   // longest interval that still quantizes, in microseconds
   localparam longint unsigned LIMIT_US = longint'(MAX_UNITS) * UNIT_US;
   localparam int HALF_US = UNIT_US / 2;
   localparam int DUR_W   = $clog2(LIMIT_US + HALF_US + 1);

   // exact reciprocal for every dividend below 2^DUR_W
   localparam int RECIP_SHIFT = DUR_W + $clog2(UNIT_US);
   localparam longint unsigned RECIP =
      ((64'd1 << RECIP_SHIFT) + UNIT_US - 1) / UNIT_US;
   localparam int RECIP_W = RECIP_SHIFT + 1;
   localparam int PROD_W  = DUR_W + RECIP_W;
   localparam int QUOT_W  = PROD_W - RECIP_SHIFT;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

   typedef logic [31:0]      stamp_type;
   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [15:0]      value_type;
   typedef logic [DUR_W-1:0] dur_type;

   typedef enum logic [1:0] {
      REQ_SAMPLE = 2'd0,
      REQ_START  = 2'd1,
      REQ_STOP   = 2'd2,
      REQ_POP    = 2'd3
   } req_kind_type;

   typedef struct packed {
      value_type read_value;
      logic      read_valid;
      logic      ring_empty;
      stamp_type overflow_total;
   } rsp_type;

endpackage

>>> sv/iredc_if.sv
interface iredc_req_if;
   import iredc_pkg::*;

   logic         valid;
   logic         ready;
   req_kind_type req_type;
   logic         pin_level;
   stamp_type    time_us;

   modport source (output valid, req_type, pin_level, time_us, input ready);
   modport sink (input valid, req_type, pin_level, time_us, output ready);
endinterface

interface iredc_rsp_if;
   import iredc_pkg::*;

   logic      valid;
   logic      ready;
   value_type read_value;
   logic      read_valid;
   logic      ring_empty;
   stamp_type overflow_total;

   modport source (output valid, read_value, read_valid, ring_empty, overflow_total,
                   input ready);
   modport sink (input valid, read_value, read_valid, ring_empty, overflow_total,
                 output ready);
endinterface

>>> sv/iredc_ram.sv
module iredc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> sv/iredc_rsp_queue.sv
module iredc_rsp_queue (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push_valid,
   input  iredc_pkg::rsp_type                 push_data,
   output logic [iredc_pkg::QUEUE_CNT_W-1:0]  fill,
   iredc_rsp_if.source                        rsp_ch
);
   import iredc_pkg::*;

   rsp_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wptr_ff, wptr_in;
   logic [QUEUE_PTR_W-1:0] rptr_ff, rptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   pop;

   assign pop  = rsp_ch.valid && rsp_ch.ready;
   assign fill = count_ff;

   assign rsp_ch.valid          = (count_ff != '0);
   assign rsp_ch.read_value     = entry_ff[rptr_ff].read_value;
   assign rsp_ch.read_valid     = entry_ff[rptr_ff].read_valid;
   assign rsp_ch.ring_empty     = entry_ff[rptr_ff].ring_empty;
   assign rsp_ch.overflow_total = entry_ff[rptr_ff].overflow_total;

   always_comb begin
      wptr_in  = push_valid ? wptr_ff + QUEUE_PTR_W'(1) : wptr_ff;
      rptr_in  = pop ? rptr_ff + QUEUE_PTR_W'(1) : rptr_ff;
      count_in = count_ff + QUEUE_CNT_W'(push_valid) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/ir_edge_duration_capture_core.sv
// Infrared pulse-width capture into a 1024-entry ring of 16-bit durations.
// One request is taken every clock cycle while req_ch.ready is high, and each
// gives one response, registered in stage one and queued. Stage zero updates the
// ring pointers, levels and frame state in flip-flops and issues the ring read
// for a pop; stage one quantizes a pushed interval with a single constant
// reciprocal multiply and writes it to the ring memory, while a pop collects
// the registered read data (forwarded when the entry is still being written).
// Responses wait in a four-entry queue, so requests keep flowing while the
// response side stalls until that queue fills. The ring holds at most 1023
// entries; a push into a full ring drops the oldest one and counts it.
// The ring memory needs no clearing after reset.
`include "ir_edge_duration_capture_core_macros.svh"

module ir_edge_duration_capture_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  iredc_pkg::stamp_type  csr_wdata,
   iredc_req_if.sink             req_ch,
   iredc_rsp_if.source           rsp_ch
);
   import iredc_pkg::*;

   function automatic ptr_type ptr_next(ptr_type p);
      return (p == ptr_type'(RING_DEPTH - 1)) ? '0 : p + ptr_type'(1);
   endfunction

   // architectural state
   stamp_type timeout_ff;
   ptr_type   wp_ff, wp_in;
   ptr_type   rp_ff, rp_in;
   logic      idle_ff, idle_in;
   logic      prev_ff, prev_in;
   stamp_type last_ff, last_in;
   logic      frame_ff, frame_in;
   logic      cap_ff, cap_in;
   stamp_type drop_ff, drop_in;

   // stage one
   logic      s1_valid_ff;
   logic      s1_push_ff;
   logic      s1_pop_ff;
   logic      s1_fwd_ff;
   logic      s1_mark_ff;
   dur_type   s1_dur_ff;
   ptr_type   s1_addr_ff;
   logic      s1_empty_ff;
   stamp_type s1_drop_ff;
   value_type s1_fwd_data_ff;

   logic                   accept;
   logic                   clear_req;
   logic                   pop_req;
   stamp_type              elapsed;
   logic                   over_limit;
   logic                   do_push;
   logic                   push_mark;
   logic                   pop_hit;
   logic                   fwd_in;
   logic [DUR_W-1:0]       rounded;
   logic [PROD_W-1:0]      product;
   logic [QUOT_W-1:0]      quot;
   value_type              push_value;
   value_type              ram_rdata;
   rsp_type                s1_rsp;
   logic [QUEUE_CNT_W-1:0] queue_fill;

   assign accept     = req_ch.valid && req_ch.ready;
   assign clear_req  = accept && (req_ch.req_type == REQ_START || req_ch.req_type == REQ_STOP);
   assign pop_req    = accept && (req_ch.req_type == REQ_POP);
   assign elapsed    = req_ch.time_us - last_ff;
   assign over_limit = (elapsed > stamp_type'(LIMIT_US));

   // room for this request after whatever is already in flight
   assign req_ch.ready = !reset &&
      ((queue_fill + QUEUE_CNT_W'(s1_valid_ff)) <= QUEUE_CNT_W'(QUEUE_DEPTH - 1));

   always_comb begin
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      idle_in   = idle_ff;
      prev_in   = prev_ff;
      last_in   = last_ff;
      frame_in  = frame_ff;
      cap_in    = cap_ff;
      drop_in   = drop_ff;
      do_push   = 1'b0;
      push_mark = 1'b0;
      pop_hit   = 1'b0;
      if (accept) begin
         unique case (req_ch.req_type)
            REQ_SAMPLE: begin
               if (cap_ff) begin
                  if (req_ch.pin_level != prev_ff) begin
                     // the edge that ends a non-idle interval opens the frame
                     if (frame_ff || (prev_ff != idle_ff)) begin
                        do_push   = 1'b1;
                        push_mark = over_limit;
                        frame_in  = 1'b1;
                     end
                     prev_in = req_ch.pin_level;
                     last_in = req_ch.time_us;
                  end else if (frame_ff && (req_ch.pin_level == idle_ff) &&
                               (elapsed >= timeout_ff)) begin
                     do_push   = 1'b1;
                     push_mark = 1'b1;
                     frame_in  = 1'b0;
                     last_in   = req_ch.time_us;
                  end
               end
            end
            REQ_START: begin
               wp_in    = '0;
               rp_in    = '0;
               idle_in  = req_ch.pin_level;
               prev_in  = req_ch.pin_level;
               last_in  = req_ch.time_us;
               frame_in = 1'b0;
               cap_in   = 1'b1;
            end
            REQ_STOP: begin
               wp_in    = '0;
               rp_in    = '0;
               frame_in = 1'b0;
               cap_in   = 1'b0;
            end
            REQ_POP: begin
               if (wp_ff != rp_ff) begin
                  pop_hit = 1'b1;
                  rp_in   = ptr_next(rp_ff);
               end
            end
            default: begin
            end
         endcase
         if (do_push) begin
            // full ring: drop the oldest entry
            if (ptr_next(wp_ff) == rp_ff) begin
               rp_in   = ptr_next(rp_ff);
               drop_in = drop_ff + 32'd1;
            end
            wp_in = ptr_next(wp_ff);
         end
      end
   end

   // the entry this pop reads is written by stage one at the same edge
   assign fwd_in = pop_hit && s1_push_ff && (s1_addr_ff == rp_ff);

   // round to nearest unit and clamp to the valid range, or store the end mark
   always_comb begin
      rounded = s1_dur_ff + DUR_W'(HALF_US);
      product = PROD_W'(rounded) * PROD_W'(RECIP);
      quot    = product[PROD_W-1:RECIP_SHIFT];
      if (s1_mark_ff) begin
         push_value = END_MARK;
      end else if (quot == '0) begin
         push_value = value_type'(1);
      end else if (quot > QUOT_W'(MAX_UNITS)) begin
         push_value = MAX_UNITS;
      end else begin
         push_value = value_type'(quot);
      end
   end

   iredc_ram #(
      .WIDTH ($bits(value_type)),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (s1_push_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (push_value),
      .rd_addr (rp_ff),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_we) begin
         timeout_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         rp_ff       <= '0;
         idle_ff     <= 1'b1;
         prev_ff     <= 1'b1;
         last_ff     <= '0;
         frame_ff    <= 1'b0;
         cap_ff      <= 1'b0;
         drop_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s1_push_ff  <= 1'b0;
         s1_pop_ff   <= 1'b0;
         s1_fwd_ff   <= 1'b0;
      end else begin
         wp_ff       <= wp_in;
         rp_ff       <= rp_in;
         idle_ff     <= idle_in;
         prev_ff     <= prev_in;
         last_ff     <= last_in;
         frame_ff    <= frame_in;
         cap_ff      <= cap_in;
         drop_ff     <= drop_in;
         s1_valid_ff <= accept;
         s1_push_ff  <= do_push;
         s1_pop_ff   <= pop_hit;
         s1_fwd_ff   <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_mark_ff     <= push_mark;
      s1_dur_ff      <= dur_type'(elapsed);
      s1_addr_ff     <= wp_ff;
      s1_empty_ff    <= (wp_in == rp_in);
      s1_drop_ff     <= drop_in;
      s1_fwd_data_ff <= push_value;
   end

   always_comb begin
      s1_rsp.read_value     = '0;
      if (s1_pop_ff) begin
         s1_rsp.read_value = s1_fwd_ff ? s1_fwd_data_ff : ram_rdata;
      end
      s1_rsp.read_valid     = s1_pop_ff;
      s1_rsp.ring_empty     = s1_empty_ff;
      s1_rsp.overflow_total = s1_drop_ff;
   end

   iredc_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (s1_valid_ff),
      .push_data  (s1_rsp),
      .fill       (queue_fill),
      .rsp_ch     (rsp_ch)
   );

   `IREDC_ASSERT_NEXT(a_accept_reaches_s1, clock, reset, accept, s1_valid_ff)
   `IREDC_ASSERT_NEXT(a_clear_empties_ring, clock, reset, clear_req, wp_ff == rp_ff)
   `IREDC_ASSERT_NEXT(a_pop_keeps_drops, clock, reset, pop_req, $stable(drop_ff))
   `IREDC_ASSERT_SAME(a_fwd_only_on_pop, clock, reset, s1_fwd_ff, s1_pop_ff && s1_valid_ff)

endmodule

>>> verif/tb_ir_edge_duration_capture_core.sv
module tb_ir_edge_duration_capture_core;
   timeunit 1ns;
   timeprecision 1ps;

   import iredc_pkg::*;

   localparam stamp_type   CEIL_US     = 32'(MAX_UNITS) * UNIT_US;
   localparam int unsigned CYCLE_LIMIT = 1000000;

   logic      clock = 1'b0;
   logic      reset;
   logic      csr_we;
   stamp_type csr_wdata;

   iredc_req_if req_ch ();
   iredc_rsp_if rsp_ch ();

   ir_edge_duration_capture_core dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // expected capture state
   value_type dur_ring [RING_DEPTH];
   ptr_type   ring_wr       = '0;
   ptr_type   ring_rd       = '0;
   logic      pred_idle_lvl = 1'b1;
   logic      pred_prev_lvl = 1'b1;
   stamp_type pred_edge_t   = '0;
   logic      pred_frame    = 1'b0;
   logic      pred_armed    = 1'b0;
   stamp_type pred_drops    = '0;
   stamp_type pred_timeout  = TIMEOUT_RESET;

   rsp_type   pending_rsp [$];
   rsp_type   want;
   bit        mismatch_seen = 1'b0;
   int unsigned cycle_count = 0;

   // stimulus-side view of the line
   bit        gaps_on = 1'b0;
   int        hold_cycles = 0;
   logic      stim_lvl;
   logic      stim_idle;
   stamp_type stim_edge;
   stamp_type stim_timeout = TIMEOUT_RESET;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      else if (r < 93) return $urandom_range(1, 3);
      else return $urandom_range(10, 30);
   endfunction

   function automatic value_type quantize_us(stamp_type us);
      stamp_type q;
      if (us > CEIL_US) return END_MARK;
      q = (us + 32'(UNIT_US / 2)) / 32'(UNIT_US);
      if (q == 0) q = 1;
      if (q > 32'(MAX_UNITS)) q = 32'(MAX_UNITS);
      return q[15:0];
   endfunction

   // full ring gives up its oldest entry
   function automatic void ring_write(value_type v);
      ptr_type nxt;
      nxt = ring_wr + 1'b1;
      if (nxt == ring_rd) begin
         ring_rd    = ring_rd + 1'b1;
         pred_drops = pred_drops + 1;
      end
      dur_ring[ring_wr] = v;
      ring_wr = nxt;
   endfunction

   function automatic void capture_predict(req_kind_type kind, logic lvl, stamp_type t);
      rsp_type   r;
      stamp_type span;
      r = '0;
      span = t - pred_edge_t;
      case (kind)
         REQ_SAMPLE: begin
            if (pred_armed) begin
               if (lvl != pred_prev_lvl) begin
                  if (pred_frame) begin
                     ring_write(quantize_us(span));
                  end else if (pred_prev_lvl != pred_idle_lvl) begin
                     pred_frame = 1'b1;
                     ring_write(quantize_us(span));
                  end
                  pred_prev_lvl = lvl;
                  pred_edge_t   = t;
               end else if (pred_frame && lvl == pred_idle_lvl && span >= pred_timeout) begin
                  ring_write(END_MARK);
                  pred_frame  = 1'b0;
                  pred_edge_t = t;
               end
            end
         end
         REQ_START: begin
            ring_wr       = '0;
            ring_rd       = '0;
            pred_idle_lvl = lvl;
            pred_prev_lvl = lvl;
            pred_edge_t   = t;
            pred_frame    = 1'b0;
            pred_armed    = 1'b1;
         end
         REQ_STOP: begin
            ring_wr    = '0;
            ring_rd    = '0;
            pred_armed = 1'b0;
            pred_frame = 1'b0;
         end
         default: begin
            if (ring_wr != ring_rd) begin
               r.read_value = dur_ring[ring_rd];
               r.read_valid = 1'b1;
               ring_rd      = ring_rd + 1'b1;
            end
         end
      endcase
      r.ring_empty     = (ring_wr == ring_rd);
      r.overflow_total = pred_drops;
      pending_rsp = {pending_rsp, r};
   endfunction

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (got_v !== exp_v) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, got_v);
         mismatch_seen = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            capture_predict(req_ch.req_type, req_ch.pin_level, req_ch.time_us);
         if (csr_we)
            pred_timeout = csr_wdata;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: response with none expected, actual value %0h", $time,
                        rsp_ch.read_value);
               mismatch_seen = 1'b1;
            end else begin
               want = pending_rsp.pop_front();
               check_field("read_value", want.read_value, rsp_ch.read_value);
               check_field("read_valid", want.read_valid, rsp_ch.read_valid);
               check_field("ring_empty", want.ring_empty, rsp_ch.ring_empty);
               check_field("overflow_total", want.overflow_total, rsp_ch.overflow_total);
            end
         end
      end
   end

   // response side back-pressure
   always @(posedge clock) begin
      if (hold_cycles != 0) begin
         hold_cycles   <= hold_cycles - 1;
         rsp_ch.ready  <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         hold_cycles   <= pick_gap();
         rsp_ch.ready  <= 1'b0;
      end else begin
         rsp_ch.ready  <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ir_edge_duration_capture_core verification failed");
         $finish;
      end
   end

   task automatic send_req(input req_kind_type kind, input logic lvl, input stamp_type t);
      int gap;
      gap = gaps_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.req_type  <= kind;
      req_ch.pin_level <= lvl;
      req_ch.time_us   <= t;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic pop_one();
      send_req(REQ_POP, 1'($urandom_range(0, 1)), $urandom());
   endtask

   task automatic start_capture(input logic lvl, input stamp_type t);
      send_req(REQ_START, lvl, t);
      stim_lvl  = lvl;
      stim_idle = lvl;
      stim_edge = t;
   endtask

   // sample taken dt after the last edge seen on the line
   task automatic pin_step(input logic lvl, input stamp_type dt);
      stamp_type t;
      t = stim_edge + dt;
      send_req(REQ_SAMPLE, lvl, t);
      if (lvl != stim_lvl || dt >= stim_timeout)
         stim_edge = t;
      stim_lvl = lvl;
   endtask

   function automatic stamp_type pick_width();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(100, 3000);
      else if (r < 80) return $urandom_range(0, 40);
      else if (r < 90) return CEIL_US - 30 + $urandom_range(0, 60);
      else if (r < 95) return $urandom();
      else return $urandom_range(3000, 200000);
   endfunction

   task automatic settle();
      req_ch.valid <= 1'b0;
      // let the last accepted request reach the expected queue first
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_timeout(input stamp_type value);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      stim_timeout = value;
      @(posedge clock);
   endtask

   task automatic test_directed_corners();
      pop_one();                                // empty ring after reset
      send_req(REQ_SAMPLE, 1'b0, 32'd5);        // ignored while stopped
      send_req(REQ_STOP, 1'b1, 32'd7);
      start_capture(1'b1, 32'hFFFF_FFA0);       // timestamps wrap shortly
      pin_step(1'b1, 32'd40);
      pin_step(1'b0, 32'd120);                  // idle interval, not stored
      pin_step(1'b1, 32'd0);                    // opens frame, clamps to one unit
      pin_step(1'b0, 32'd10);
      pin_step(1'b1, 32'd11);
      pin_step(1'b0, 32'd31);
      pin_step(1'b1, 32'd32);
      pin_step(1'b0, CEIL_US);
      pin_step(1'b1, CEIL_US + 1);
      pin_step(1'b0, 32'hFFFF_FFFF);
      pin_step(1'b1, 32'd500);
      pin_step(1'b1, TIMEOUT_RESET - 1);
      pin_step(1'b1, TIMEOUT_RESET);            // idle past timeout ends frame
      pop_one();
      pop_one();
      start_capture(1'b0, $urandom());          // restart clears the ring
      pop_one();
      pin_step(1'b1, 32'd300);
      pin_step(1'b0, 32'd400);
      pop_one();
      send_req(REQ_STOP, 1'b0, $urandom());
      pop_one();
   endtask

   task automatic test_ring_overflow();
      start_capture(1'b1, $urandom());
      for (int i = 0; i < 1060; i++) begin
         if (i == 500) gaps_on = 1'b1;
         pin_step(~stim_lvl, pick_width());
      end
      repeat (12) pop_one();
      send_req(REQ_STOP, 1'b1, $urandom());
      pop_one();
   endtask

   task automatic test_random_traffic(input int count);
      int           pick;
      req_kind_type kind;
      logic         lvl;
      stamp_type    t;
      start_capture(1'($urandom_range(0, 1)), $urandom());
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            start_capture(1'($urandom_range(0, 1)), $urandom());
         end else if (pick < 5) begin
            send_req(REQ_STOP, 1'($urandom_range(0, 1)), $urandom());
         end else if (pick < 25) begin
            pop_one();
         end else if (pick < 30) begin
            kind = req_kind_type'($urandom_range(0, 3));
            lvl  = 1'($urandom_range(0, 1));
            t    = $urandom();
            send_req(kind, lvl, t);
            if (kind == REQ_START) begin
               stim_idle = lvl;
               stim_lvl  = lvl;
               stim_edge = t;
            end else if (kind == REQ_SAMPLE) begin
               stim_lvl  = lvl;
               stim_edge = t;
            end
         end else if (pick < 42 && stim_lvl == stim_idle) begin
            // rest at the idle level, mostly around the timeout
            case ($urandom_range(0, 3))
               0: t = stim_timeout - 1;
               1: t = stim_timeout;
               2: t = stim_timeout + $urandom_range(1, 5000);
               default: t = $urandom_range(0, 3000);
            endcase
            pin_step(stim_lvl, t);
         end else begin
            pin_step(~stim_lvl, pick_width());
         end
      end
   endtask

   task automatic test_timeout_setting(input stamp_type value, input int count);
      settle();
      write_timeout(value);
      gaps_on = ($urandom_range(0, 3) != 0);
      test_random_traffic(count);
   endtask

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_wdata        = '0;
      req_ch.valid     = 1'b0;
      req_ch.req_type  = REQ_SAMPLE;
      req_ch.pin_level = 1'b0;
      req_ch.time_us   = '0;
      rsp_ch.ready     = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_corners();
      settle();
      test_ring_overflow();
      test_timeout_setting(32'd0, 120);
      test_timeout_setting(32'd1, 120);
      test_timeout_setting(32'hFFFF_FFFF, 120);
      test_timeout_setting($urandom_range(200, 60000), 150);
      test_timeout_setting(TIMEOUT_RESET, 120);
      settle();

      if (!mismatch_seen && pending_rsp.size() == 0) begin
         $display("ir_edge_duration_capture_core verification clean");
      end else begin
         if (pending_rsp.size() != 0)
            $display("%0t: %0d responses never arrived", $time, pending_rsp.size());
         $display("ir_edge_duration_capture_core verification failed");
      end
      $finish;
   end

endmodule
